FILE: rtl/core/wtss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed trapezoid statistics package
// Shared sizes, command and register codes, sequencer states and the status
// bundle of the long divider.
// ----------------------------------------------------------------------------
package wtss_pkg;

  // Sample store depth and derived widths.
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  // Linear sums: each term is below 2^64, summed over at most MAX_SAMPLES terms.
  localparam int LIN_W       = 65 + ADDR_W;
  // Square sums: each term is below 2^96.
  localparam int SQ_W        = 97 + ADDR_W;
  // Operand width of the shared multiplier.
  localparam int MUL_W       = 33;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1,
    CFG_WHOLE_SIGNAL = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DSEL_MEAN,
    DSEL_SQ,
    DSEL_DSQ,
    DSEL_DAB
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDLO,
    ST_RDHI,
    ST_CHECK,
    ST_FETCH,
    ST_LOAD,
    ST_MUL_DTM,
    ST_MUL_MM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV,
    ST_SQRT,
    ST_SQRT_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/wtss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed trapezoid statistics channels
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wtss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        time_stamp;
  logic signed [15:0] sample_value;

  modport source (output valid, cmd, time_stamp, sample_value, input ready);
  modport sink   (input valid, cmd, time_stamp, sample_value, output ready);
endinterface

interface wtss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_value;
  logic [30:0]        rms_value;
  logic [30:0]        rms_deviation;
  logic [30:0]        mean_abs_deviation;
  logic               error_flag;

  modport source (output valid, mean_value, rms_value, rms_deviation,
                  mean_abs_deviation, error_flag, input ready);
  modport sink   (input valid, mean_value, rms_value, rms_deviation,
                  mean_abs_deviation, error_flag, output ready);
endinterface

interface wtss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/windowed_trapezoid_signal_stats.sv
`timescale 1ns / 1ps
// Append and clear items are taken one item per cycle while the sequencer is idle.
// A compute item first scans the stored samples when windowed, then walks the window
// in two passes; the bit-serial divider (one bit per cycle, SQ_W = 107 bits) dominates.
// The input is not ready while a compute item is in progress.
// Synchronous active-low reset empties the store and restores the control registers.
// ----------------------------------------------------------------------------
// Windowed trapezoid signal statistics
// Sample store with a sequencer that walks a window twice through one shared
// multiplier, divides by the span after each pass and takes square roots iteratively.
// ----------------------------------------------------------------------------
module windowed_trapezoid_signal_stats (
  input  logic             clk,
  input  logic             rst_n,
  wtss_in_if.sink          in_if,
  wtss_out_if.source       out_if,
  wtss_cfg_if.sink         cfg_if
);

  localparam int AW = wtss_pkg::ADDR_W;
  localparam int CW = wtss_pkg::CNT_W;
  localparam int LW = wtss_pkg::LIN_W;
  localparam int QW = wtss_pkg::SQ_W;
  localparam int MW = wtss_pkg::MUL_W;

  // Sample store.
  logic [31:0]        time_mem  [wtss_pkg::MAX_SAMPLES];
  logic signed [15:0] value_mem [wtss_pkg::MAX_SAMPLES];
  logic [31:0]        rd_t_r;
  logic signed [15:0] rd_y_r;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;

  // Control state.
  wtss_pkg::state_t   state_r, state_nxt;
  wtss_pkg::div_sel_t div_sel_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      scan_r;
  logic [31:0]        window_start_r, window_end_r;
  logic               whole_signal_r;
  logic signed [31:0] held_mean_r;
  logic               out_valid_r;
  logic               pass_r;
  logic               first_r;
  logic [4:0]         scnt_r;

  // Working registers.
  logic [AW-1:0]      lo_r, hi_r, idx_r;
  logic [31:0]        tlo_r, span_r;
  logic [31:0]        prev_t_r;
  logic signed [15:0] prev_y_r;
  logic [31:0]        dt_r;
  logic [MW-1:0]      m_r;
  logic               neg_r;
  logic [2*MW-1:0]    prod_r;
  logic [MW-1:0]      mmhi_r;
  logic [LW-1:0]      pos_r, negacc_r, dab_r;
  logic [QW-1:0]      sq_r, dsq_r;
  logic [63:0]        sv_r, sres_r, sbit_r;
  logic signed [31:0] mean_res_r;
  logic [30:0]        rms_r, rmsd_r, mad_r;
  logic               err_r;

  // Output register.
  logic signed [31:0] out_mean_r;
  logic [30:0]        out_rms_r, out_rmsd_r, out_mad_r;
  logic               out_err_r;

  // Handshakes and shared units.
  logic               in_acc, cfg_acc, out_acc;
  logic               in_rdy;
  logic [MW-1:0]      mul_a, mul_b;
  logic               div_start;
  logic [QW-1:0]      div_num;
  logic [QW-1:0]      quo;
  wtss_pkg::div_stat_t div_stat;

  // Combinational helpers.
  logic               window_bad;
  logic               mean_neg;
  logic [LW-1:0]      mag;
  logic signed [16:0] ysum;
  logic signed [31:0] mid;
  logic [32:0]        mid_abs;
  logic signed [33:0] dev;
  logic [32:0]        dev_abs;
  logic [31:0]        dt_cur;
  logic signed [31:0] mean_q;
  logic               sat31, sat_sqrt;
  logic [63:0]        s_try;
  logic               fin_load;

  assign in_acc  = in_if.valid && in_rdy;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;
  assign out_acc = out_if.valid && out_if.ready;
  assign mem_we  = in_acc && (wtss_pkg::cmd_t'(in_if.cmd) == wtss_pkg::CMD_APPEND) &&
                   (count_r < CW'(wtss_pkg::MAX_SAMPLES));
  assign fin_load = (state_r == wtss_pkg::ST_FIN) && (!out_valid_r || out_if.ready);

  // Store write at the fill count; registered read at the sequencer address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[count_r[AW-1:0]]  <= in_if.time_stamp;
      value_mem[count_r[AW-1:0]] <= in_if.sample_value;
    end
    rd_t_r <= time_mem[rd_addr];
    rd_y_r <= value_mem[rd_addr];
  end

  wtss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (span_r),
    .stat  (div_stat),
    .quo   (quo)
  );

  // Interval terms from the previous and current samples.
  always_comb begin
    ysum    = 17'(prev_y_r) + 17'(rd_y_r);
    mid     = {ysum, 15'd0};
    mid_abs = mid[31] ? (33'd0 - {1'b1, mid}) : {1'b0, mid};
    dev     = 34'(mid) - 34'(held_mean_r);
    dev_abs = dev[33] ? 33'(34'd0 - dev) : dev[32:0];
    dt_cur  = (rd_t_r > prev_t_r) ? (rd_t_r - prev_t_r) : 32'd0;
  end

  // Window check, mean sign, saturation tests and the square-root trial.
  always_comb begin
    window_bad = (hi_r <= lo_r) || (rd_t_r <= tlo_r);
    mean_neg   = (negacc_r > pos_r);
    mag        = mean_neg ? (negacc_r - pos_r) : (pos_r - negacc_r);
    sat31      = |quo[QW-1:31];
    sat_sqrt   = |quo[QW-1:62];
    if (mean_neg) begin
      mean_q = sat31 ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end else begin
      mean_q = sat31 ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end
    s_try = sres_r + sbit_r;
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wtss_pkg::ST_IDLE: begin
        if (in_acc && (wtss_pkg::cmd_t'(in_if.cmd) == wtss_pkg::CMD_COMPUTE)) begin
          if (count_r < CW'(2)) state_nxt = wtss_pkg::ST_FIN;
          else if (whole_signal_r) state_nxt = wtss_pkg::ST_RDLO;
          else state_nxt = wtss_pkg::ST_SCAN;
        end
      end
      wtss_pkg::ST_SCAN:    if (scan_r == count_r) state_nxt = wtss_pkg::ST_RDLO;
      wtss_pkg::ST_RDLO:    state_nxt = wtss_pkg::ST_RDHI;
      wtss_pkg::ST_RDHI:    state_nxt = wtss_pkg::ST_CHECK;
      wtss_pkg::ST_CHECK:   state_nxt = window_bad ? wtss_pkg::ST_FIN : wtss_pkg::ST_FETCH;
      wtss_pkg::ST_FETCH:   state_nxt = wtss_pkg::ST_LOAD;
      wtss_pkg::ST_LOAD:    state_nxt = first_r ? wtss_pkg::ST_FETCH : wtss_pkg::ST_MUL_DTM;
      wtss_pkg::ST_MUL_DTM: state_nxt = wtss_pkg::ST_MUL_MM;
      wtss_pkg::ST_MUL_MM:  state_nxt = wtss_pkg::ST_MUL_LO;
      wtss_pkg::ST_MUL_LO:  state_nxt = wtss_pkg::ST_MUL_HI;
      wtss_pkg::ST_MUL_HI:  state_nxt = wtss_pkg::ST_ACC;
      wtss_pkg::ST_ACC: begin
        state_nxt = (idx_r == hi_r) ? wtss_pkg::ST_DIV_GO : wtss_pkg::ST_FETCH;
      end
      wtss_pkg::ST_DIV_GO:  state_nxt = wtss_pkg::ST_DIV;
      wtss_pkg::ST_DIV: begin
        if (div_stat.done) begin
          case (div_sel_r)
            wtss_pkg::DSEL_MEAN: state_nxt = wtss_pkg::ST_FETCH;
            wtss_pkg::DSEL_SQ,
            wtss_pkg::DSEL_DSQ: begin
              state_nxt = sat_sqrt ? wtss_pkg::ST_DIV_GO : wtss_pkg::ST_SQRT;
            end
            default: state_nxt = wtss_pkg::ST_FIN;
          endcase
        end
      end
      wtss_pkg::ST_SQRT:    if (scnt_r == 5'd31) state_nxt = wtss_pkg::ST_SQRT_WR;
      wtss_pkg::ST_SQRT_WR: state_nxt = wtss_pkg::ST_DIV_GO;
      wtss_pkg::ST_FIN:     if (fin_load) state_nxt = wtss_pkg::ST_IDLE;
      default:              state_nxt = wtss_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: read address, multiplier operands, divider start.
  always_comb begin
    in_rdy    = (state_r == wtss_pkg::ST_IDLE);
    div_start = (state_r == wtss_pkg::ST_DIV_GO);
    rd_addr   = idx_r;
    mul_a     = {1'b0, dt_r};
    mul_b     = m_r;
    case (state_r)
      wtss_pkg::ST_SCAN: rd_addr = scan_r[AW-1:0];
      wtss_pkg::ST_RDLO: rd_addr = lo_r;
      wtss_pkg::ST_RDHI: rd_addr = hi_r;
      wtss_pkg::ST_MUL_MM: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      wtss_pkg::ST_MUL_LO: mul_b = prod_r[MW-1:0];
      wtss_pkg::ST_MUL_HI: mul_b = mmhi_r;
      default: rd_addr = idx_r;
    endcase
    case (div_sel_r)
      wtss_pkg::DSEL_MEAN: div_num = QW'(mag);
      wtss_pkg::DSEL_SQ:   div_num = sq_r;
      wtss_pkg::DSEL_DSQ:  div_num = dsq_r;
      default:             div_num = QW'(dab_r);
    endcase
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Control registers: state, fill count, configuration, held mean, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= wtss_pkg::ST_IDLE;
      count_r        <= '0;
      window_start_r <= 32'd0;
      window_end_r   <= 32'hFFFF_FFFF;
      whole_signal_r <= 1'b1;
      held_mean_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) count_r <= count_r + CW'(1);
      if (in_acc && (wtss_pkg::cmd_t'(in_if.cmd) == wtss_pkg::CMD_CLEAR)) count_r <= '0;
      if (cfg_acc) begin
        case (wtss_pkg::cfg_idx_t'(cfg_if.index))
          wtss_pkg::CFG_WINDOW_START: window_start_r <= cfg_if.data;
          wtss_pkg::CFG_WINDOW_END:   window_end_r   <= cfg_if.data;
          wtss_pkg::CFG_WHOLE_SIGNAL: whole_signal_r <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (state_r == wtss_pkg::ST_DIV && div_stat.done && div_sel_r == wtss_pkg::DSEL_MEAN) begin
        held_mean_r <= mean_q;
      end
      if (fin_load) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      wtss_pkg::ST_IDLE: begin
        err_r      <= 1'b1;
        mean_res_r <= '0;
        rms_r      <= '0;
        rmsd_r     <= '0;
        mad_r      <= '0;
        lo_r       <= '0;
        hi_r       <= AW'(count_r - CW'(1));
        scan_r     <= '0;
      end
      wtss_pkg::ST_SCAN: begin
        // Data read in the previous cycle belongs to entry scan_r - 1.
        if (scan_r != '0) begin
          if (rd_t_r < window_start_r) lo_r <= AW'(scan_r - CW'(1));
          if (rd_t_r < window_end_r)   hi_r <= AW'(scan_r - CW'(1));
        end
        scan_r <= scan_r + CW'(1);
      end
      wtss_pkg::ST_RDHI: tlo_r <= rd_t_r;
      wtss_pkg::ST_CHECK: begin
        span_r   <= rd_t_r - tlo_r;
        idx_r    <= lo_r;
        first_r  <= 1'b1;
        pass_r   <= 1'b0;
        pos_r    <= '0;
        negacc_r <= '0;
        sq_r     <= '0;
      end
      wtss_pkg::ST_LOAD: begin
        prev_t_r <= rd_t_r;
        prev_y_r <= rd_y_r;
        dt_r     <= dt_cur;
        m_r      <= pass_r ? dev_abs : mid_abs;
        neg_r    <= mid[31];
        if (first_r) begin
          first_r <= 1'b0;
          idx_r   <= idx_r + AW'(1);
        end
      end
      wtss_pkg::ST_MUL_MM: begin
        // prod_r holds dt * m.
        if (pass_r) dab_r <= dab_r + LW'(prod_r);
        else if (neg_r) negacc_r <= negacc_r + LW'(prod_r);
        else pos_r <= pos_r + LW'(prod_r);
      end
      wtss_pkg::ST_MUL_LO: mmhi_r <= prod_r[2*MW-1:MW];
      wtss_pkg::ST_MUL_HI: begin
        // prod_r holds dt times the low half of m squared.
        if (pass_r) dsq_r <= dsq_r + QW'(prod_r);
        else sq_r <= sq_r + QW'(prod_r);
      end
      wtss_pkg::ST_ACC: begin
        // prod_r holds dt times the high half of m squared.
        if (pass_r) dsq_r <= dsq_r + (QW'(prod_r) << MW);
        else sq_r <= sq_r + (QW'(prod_r) << MW);
        if (idx_r == hi_r) begin
          div_sel_r <= pass_r ? wtss_pkg::DSEL_SQ : wtss_pkg::DSEL_MEAN;
        end else begin
          idx_r <= idx_r + AW'(1);
        end
      end
      wtss_pkg::ST_DIV: begin
        if (div_stat.done) begin
          case (div_sel_r)
            wtss_pkg::DSEL_MEAN: begin
              mean_res_r <= mean_q;
              pass_r     <= 1'b1;
              idx_r      <= lo_r;
              first_r    <= 1'b1;
              dsq_r      <= '0;
              dab_r      <= '0;
            end
            wtss_pkg::DSEL_SQ,
            wtss_pkg::DSEL_DSQ: begin
              sv_r   <= quo[63:0];
              sres_r <= '0;
              sbit_r <= 64'd1 << 62;
              scnt_r <= '0;
              if (sat_sqrt) begin
                if (div_sel_r == wtss_pkg::DSEL_SQ) begin
                  rms_r     <= 31'h7FFF_FFFF;
                  div_sel_r <= wtss_pkg::DSEL_DSQ;
                end else begin
                  rmsd_r    <= 31'h7FFF_FFFF;
                  div_sel_r <= wtss_pkg::DSEL_DAB;
                end
              end
            end
            default: begin
              mad_r <= sat31 ? 31'h7FFF_FFFF : quo[30:0];
              err_r <= 1'b0;
            end
          endcase
        end
      end
      wtss_pkg::ST_SQRT: begin
        // One result bit per cycle, two radicand bits per step.
        if (sv_r >= s_try) begin
          sv_r   <= sv_r - s_try;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        scnt_r <= scnt_r + 5'd1;
      end
      wtss_pkg::ST_SQRT_WR: begin
        if (div_sel_r == wtss_pkg::DSEL_SQ) begin
          rms_r     <= sres_r[30:0];
          div_sel_r <= wtss_pkg::DSEL_DSQ;
        end else begin
          rmsd_r    <= sres_r[30:0];
          div_sel_r <= wtss_pkg::DSEL_DAB;
        end
      end
      default: ;
    endcase
  end

  // Result register loaded when the compute item finishes.
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_mean_r <= mean_res_r;
      out_rms_r  <= rms_r;
      out_rmsd_r <= rmsd_r;
      out_mad_r  <= mad_r;
      out_err_r  <= err_r;
    end
  end

  assign in_if.ready               = in_rdy;
  assign cfg_if.ready              = 1'b1;
  assign out_if.valid              = out_valid_r;
  assign out_if.mean_value         = out_mean_r;
  assign out_if.rms_value          = out_rms_r;
  assign out_if.rms_deviation      = out_rmsd_r;
  assign out_if.mean_abs_deviation = out_mad_r;
  assign out_if.error_flag         = out_err_r;

  // The fill count never passes the store depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(wtss_pkg::MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // An error result carries all-zero statistics.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.error_flag) |->
      (out_if.mean_value == 32'sd0 && out_if.rms_value == 31'd0 &&
       out_if.rms_deviation == 31'd0 && out_if.mean_abs_deviation == 31'd0))
    else $error("error result with nonzero statistics");

  // The divider is never left running once the sequencer is idle.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wtss_pkg::ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

endmodule

FILE: rtl/core/wtss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long divider
// Restoring divider, one quotient bit per cycle, wide numerator by a 32-bit
// divisor. The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module wtss_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wtss_pkg::SQ_W-1:0] num,
  input  logic [31:0]               den,
  output wtss_pkg::div_stat_t       stat,
  output logic [wtss_pkg::SQ_W-1:0] quo
);

  localparam int NW = wtss_pkg::SQ_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [NW-1:0] nsh_r;
  logic [NW-1:0] quo_r;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_sub;
  logic          ge;

  // One restoring step: bring down the next bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_r, nsh_r[NW-1]};
    ge      = (rem_sh >= {1'b0, den});
    rem_sub = ge ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, numerator shifter and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nsh_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_sub[31:0];
      nsh_r <= {nsh_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

FILE: dv/windowed_trapezoid_signal_stats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed trapezoid signal statistics testbench
// Drives append, compute and clear items into the block under several window
// settings and idling patterns. Every result is checked against an in-bench
// prediction of the time-weighted mean, RMS, RMS deviation and mean absolute
// deviation, and the error flag.
// ----------------------------------------------------------------------------
module windowed_trapezoid_signal_stats_tb;

  localparam int          CYCLE_LIMIT   = 4000000;
  localparam int          SETTLE_CYCLES = 40;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [30:0] SAT31         = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [30:0]        rms;
    logic [30:0]        rms_dev;
    logic [30:0]        abs_dev;
    logic               err;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n;
  logic recv_ready = 1'b0;

  wtss_in_if  in_ch ();
  wtss_out_if out_ch ();
  wtss_cfg_if cfg_ch ();

  assign out_ch.ready = recv_ready;

  windowed_trapezoid_signal_stats uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted block state.
  logic [31:0]        ts_mem [wtss_pkg::MAX_SAMPLES];
  logic signed [15:0] val_mem [wtss_pkg::MAX_SAMPLES];
  int unsigned        stored_cnt;
  logic signed [31:0] mean_hold;
  logic [31:0]        win_lo_ts;
  logic [31:0]        win_hi_ts;
  logic               whole_mode;

  stats_t expected_stats [$];
  int     fail_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     items_sent = 0;
  int     hold_len = 0;
  logic   hold_toggle = 1'b0;

  // Floor square root, saturated to 31 bits for large inputs.
  function automatic logic [30:0] sqrt_sat(logic [127:0] q);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    if (q >= (128'd1 << 62)) return SAT31;
    v = q[63:0];
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[30:0];
  endfunction

  function automatic logic [30:0] clamp31(logic [127:0] q);
    return (q > 128'h7FFF_FFFF) ? SAT31 : q[30:0];
  endfunction

  function automatic logic [63:0] interval_dt(int unsigned i);
    return (ts_mem[i] > ts_mem[i-1]) ? {32'd0, ts_mem[i] - ts_mem[i-1]} : 64'd0;
  endfunction

  function automatic longint interval_mid(int unsigned i);
    return (longint'(val_mem[i]) + longint'(val_mem[i-1])) * 32768;
  endfunction

  // Statistics of the current window, updating the held mean on success.
  function automatic stats_t window_stats();
    stats_t      s;
    int unsigned lo, hi;
    logic [31:0] span;
    logic [127:0] pos, neg, sq, dsq, dab, mag, q, dt, m;
    longint      v;
    s = '0;
    s.err = 1'b1;
    pos = 0; neg = 0; sq = 0; dsq = 0; dab = 0;
    if (stored_cnt < 2) return s;
    lo = 0;
    hi = stored_cnt - 1;
    if (!whole_mode) begin
      hi = stored_cnt;
      for (int unsigned i = 0; i < stored_cnt; i++) begin
        if (ts_mem[i] < win_lo_ts) lo = i;
        if (ts_mem[i] < win_hi_ts) hi = i;
      end
      if (hi > stored_cnt - 1) hi = stored_cnt - 1;
    end
    if (hi <= lo || ts_mem[hi] <= ts_mem[lo]) return s;
    span = ts_mem[hi] - ts_mem[lo];

    // First pass: signed linear sum and square sum.
    for (int unsigned i = lo + 1; i <= hi; i++) begin
      dt = interval_dt(i);
      v = interval_mid(i);
      m = (v >= 0) ? v : -v;
      if (v >= 0) pos = pos + dt * m;
      else neg = neg + dt * m;
      sq = sq + dt * (m * m);
    end
    if (neg > pos) begin
      mag = neg - pos;
      q = mag / span;
      mean_hold = (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      mag = pos - neg;
      q = mag / span;
      mean_hold = {1'b0, clamp31(q)};
    end

    // Second pass: deviations from the new mean.
    for (int unsigned i = lo + 1; i <= hi; i++) begin
      dt = interval_dt(i);
      v = interval_mid(i) - longint'(mean_hold);
      m = (v >= 0) ? v : -v;
      dsq = dsq + dt * (m * m);
      dab = dab + dt * m;
    end
    s.mean = mean_hold;
    s.rms = sqrt_sat(sq / span);
    s.rms_dev = sqrt_sat(dsq / span);
    s.abs_dev = clamp31(dab / span);
    s.err = 1'b0;
    return s;
  endfunction

  // Apply one accepted item to the predicted state.
  function automatic void apply_item(logic [1:0] c, logic [31:0] t, logic signed [15:0] v);
    case (c)
      wtss_pkg::CMD_APPEND: begin
        if (stored_cnt < wtss_pkg::MAX_SAMPLES) begin
          ts_mem[stored_cnt] = t;
          val_mem[stored_cnt] = v;
          stored_cnt++;
        end
      end
      wtss_pkg::CMD_COMPUTE: expected_stats.push_back(window_stats());
      wtss_pkg::CMD_CLEAR: stored_cnt = 0;
      default: ;
    endcase
  endfunction

  // Offer one item and wait until it is taken, then maybe leave a gap.
  task automatic send_item(logic [1:0] c, logic [31:0] t, logic signed [15:0] v);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.time_stamp <= t;
    in_ch.sample_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(c, t, v);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(wtss_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      wtss_pkg::CFG_WINDOW_START: win_lo_ts = data;
      wtss_pkg::CFG_WINDOW_END: win_hi_ts = data;
      wtss_pkg::CFG_WHOLE_SIGNAL: whole_mode = data[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(logic whole, logic [31:0] lo_ts, logic [31:0] hi_ts);
    drain();
    write_reg(wtss_pkg::CFG_WINDOW_START, lo_ts);
    write_reg(wtss_pkg::CFG_WINDOW_END, hi_ts);
    write_reg(wtss_pkg::CFG_WHOLE_SIGNAL, {31'd0, whole});
  endtask

  // Receiver: random stalls plus a long hold-off when requested.
  always @(posedge clk) begin : receiver
    int   hold_cnt;
    logic seen_toggle;
    if (!rst_n) begin
      hold_cnt = 0;
      seen_toggle = hold_toggle;
      recv_ready <= 1'b0;
    end else begin
      if (seen_toggle != hold_toggle) begin
        seen_toggle = hold_toggle;
        hold_cnt = hold_len;
      end
      if (hold_cnt > 0) hold_cnt--;
      recv_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    stats_t exp_s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("unexpected result item");
        fail_count++;
      end else begin
        exp_s = expected_stats.pop_front();
        if (out_ch.mean_value !== exp_s.mean) begin
          $error("mean_value: expected %0d, actual %0d", exp_s.mean, out_ch.mean_value);
          fail_count++;
        end
        if (out_ch.rms_value !== exp_s.rms) begin
          $error("rms_value: expected %0d, actual %0d", exp_s.rms, out_ch.rms_value);
          fail_count++;
        end
        if (out_ch.rms_deviation !== exp_s.rms_dev) begin
          $error("rms_deviation: expected %0d, actual %0d", exp_s.rms_dev,
                 out_ch.rms_deviation);
          fail_count++;
        end
        if (out_ch.mean_abs_deviation !== exp_s.abs_dev) begin
          $error("mean_abs_deviation: expected %0d, actual %0d", exp_s.abs_dev,
                 out_ch.mean_abs_deviation);
          fail_count++;
        end
        if (out_ch.error_flag !== exp_s.err) begin
          $error("error_flag: expected %0d, actual %0d", exp_s.err, out_ch.error_flag);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("windowed_trapezoid_signal_stats_tb failed");
      $finish;
    end
  end

  // Short runs, too few samples, zero span, saturating extremes and odd items.
  task automatic test_corner_items();
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    send_item(wtss_pkg::CMD_APPEND, 32'd100, 16'sd5);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    send_item(wtss_pkg::CMD_APPEND, 32'd100, -16'sd5);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    send_item(wtss_pkg::CMD_CLEAR, 0, 0);
    send_item(wtss_pkg::CMD_APPEND, 32'd0, -16'sd32768);
    send_item(wtss_pkg::CMD_APPEND, 32'hFFFF_FFFF, -16'sd32768);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    send_item(wtss_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'sh7FFF);
    send_item(wtss_pkg::CMD_APPEND, 32'd0, 16'sd32767);
    send_item(wtss_pkg::CMD_APPEND, 32'hFFFF_FFFF, 16'sd32767);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    // A falling timestamp counts as a zero-length interval.
    send_item(wtss_pkg::CMD_APPEND, 32'd7, -16'sd32768);
    send_item(wtss_pkg::CMD_APPEND, 32'hFFFF_FFFF, 16'sd1);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    send_item(CMD_UNUSED, 32'h5555_AAAA, 16'sh55AA);
    send_item(wtss_pkg::CMD_COMPUTE, 32'hAAAA_5555, -16'sh55AB);
    send_item(wtss_pkg::CMD_CLEAR, 0, 0);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
  endtask

  // Window bounds at their extremes and in the middle of the data.
  task automatic test_window_bounds();
    logic [31:0] lo_list [5] = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd25, 32'd45};
    logic [31:0] hi_list [5] = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd55, 32'd30};
    for (int k = 0; k < 5; k++) begin
      set_window(1'b0, lo_list[k], hi_list[k]);
      send_item(wtss_pkg::CMD_CLEAR, 0, 0);
      for (int i = 0; i < 8; i++) begin
        send_item(wtss_pkg::CMD_APPEND, 32'd10 * i, 16'($urandom));
      end
      send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    end
  endtask

  // Fill the store past its depth; the extra appends are dropped.
  task automatic test_full_store();
    logic [31:0] t;
    set_window(1'b1, 32'd0, 32'hFFFF_FFFF);
    send_item(wtss_pkg::CMD_CLEAR, 0, 0);
    t = $urandom;
    for (int i = 0; i < wtss_pkg::MAX_SAMPLES + 6; i++) begin
      send_item(wtss_pkg::CMD_APPEND, t, 16'($urandom));
      t = t + $urandom_range(0, 5000);
    end
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    set_window(1'b0, t - 32'd1000000, t - 32'd20000);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
  endtask

  // The receiver holds off long while computes queue up at the input.
  task automatic test_backpressure();
    set_window(1'b1, 32'd0, 32'hFFFF_FFFF);
    send_item(wtss_pkg::CMD_CLEAR, 0, 0);
    for (int i = 0; i < 6; i++) begin
      send_item(wtss_pkg::CMD_APPEND, 32'd1000 * i, 16'($urandom));
    end
    hold_len = 3000;
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 5; i++) send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    send_item(wtss_pkg::CMD_APPEND, 32'd9000, 16'sd300);
    send_item(wtss_pkg::CMD_COMPUTE, 0, 0);
    drain();
  endtask

  // One random sample sequence, with computes spread through it.
  task automatic random_sequence();
    logic [31:0]        t, base;
    logic signed [15:0] v;
    int                 k;
    base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 100000);
    k = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 30);
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(3))
        0: set_window(1'b1, $urandom, $urandom);
        1: set_window(1'b0, 32'd0, 32'hFFFF_FFFF);
        default: set_window(1'b0, base + $urandom_range(0, k * 500),
                            base + $urandom_range(0, k * 1100));
      endcase
    end
    send_item(wtss_pkg::CMD_CLEAR, $urandom, 16'($urandom));
    t = base;
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(15))
        0: v = -16'sd32768;
        1: v = 16'sd32767;
        default: v = 16'($urandom);
      endcase
      send_item(wtss_pkg::CMD_APPEND, t, v);
      case ($urandom_range(15))
        0, 1: ;
        2: t = t - $urandom_range(1, 300);
        3: t = t + $urandom;
        default: t = t + $urandom_range(1, 1000);
      endcase
      if ($urandom_range(5) == 0) begin
        send_item(wtss_pkg::CMD_COMPUTE, $urandom, 16'($urandom));
      end
      if ($urandom_range(40) == 0) send_item(CMD_UNUSED, $urandom, 16'($urandom));
    end
    send_item(wtss_pkg::CMD_COMPUTE, $urandom, 16'($urandom));
  endtask

  task automatic test_random(int target);
    int start;
    int idle_modes [4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{9, 9}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_modes[p][0];
      recv_stall_pct = idle_modes[p][1];
      start = items_sent;
      while (items_sent - start < target / 4) random_sequence();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= wtss_pkg::CMD_APPEND;
    in_ch.time_stamp <= '0;
    in_ch.sample_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= wtss_pkg::CFG_WINDOW_START;
    cfg_ch.data <= '0;
    stored_cnt = 0;
    mean_hold = 0;
    win_lo_ts = 32'd0;
    win_hi_ts = 32'hFFFF_FFFF;
    whole_mode = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed tests send about 1120 items; the random phase fills up the rest.
    test_corner_items();
    test_window_bounds();
    test_full_store();
    test_backpressure();
    test_random(320);

    drain();
    if (fail_count == 0) begin
      $display("windowed_trapezoid_signal_stats_tb passed");
    end else begin
      $display("windowed_trapezoid_signal_stats_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/wtss_pkg.sv
rtl/core/wtss_if.sv
rtl/core/wtss_div.sv
rtl/core/windowed_trapezoid_signal_stats.sv
dv/windowed_trapezoid_signal_stats_tb.sv
